// ----- design/bounded_deque_engine_macros.svh -----
// assertion macros for the deque engine
`ifndef BOUNDED_DEQUE_ENGINE_MACROS_SVH
`define BOUNDED_DEQUE_ENGINE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BDE_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("deque engine check failed");

// next-cycle implication, checked out of reset
`define BDE_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("deque engine check failed");

`endif

// ----- design/bde_pkg.sv -----
// shared constants, codes and types of the deque engine
package bde_pkg;

  localparam int DEPTH = 32;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_BACK   = 3'd3;
  localparam logic [2:0] REQ_LIST       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic signed [WORD_W-1:0] ld;
  } cell_ctl_t;

endpackage

// ----- design/bde_req_if.sv -----
// request channel: request kind and word to push
interface bde_req_if
  import bde_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [2:0]               req_type;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

// ----- design/bde_rsp_if.sv -----
// result channel: listed word, status and last flag
interface bde_rsp_if
  import bde_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] item;
  logic [1:0]               status;
  logic                     last;

  modport source (output valid, output item, output status, output last, input ready);
  modport sink (input valid, input item, input status, input last, output ready);
endinterface

// ----- design/bde_cell.sv -----
// one storage cell of the deque row
module bde_cell
  import bde_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [WORD_W-1:0] left_d,
  input  logic signed [WORD_W-1:0] right_d,
  output logic signed [WORD_W-1:0] q
);

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_FROM_LEFT:  q <= left_d;
      CELL_FROM_RIGHT: q <= right_d;
      CELL_LOAD:       q <= ctl.ld;
      default:         q <= q;
    endcase
  end

endmodule

// ----- design/bounded_deque_engine.sv -----
// deque engine top level: control, output register and row of cells
// push and pop: one word a cycle unless rsp stalls; result registered at accept
// listing: the row rotates once round through cell zero, pausing while
//   the result side stalls and an element waits
// rst clears occupancy, state and the output valid; cell contents are not reset
// the front element sits in cell zero whenever the engine is idle
`include "bounded_deque_engine_macros.svh"
module bounded_deque_engine
  import bde_pkg::*;
(
  input logic      clk,
  input logic      rst,
  bde_req_if.sink  req,
  bde_rsp_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] k, k_next;

  logic                     out_valid;
  logic signed [WORD_W-1:0] out_item;
  logic [1:0]               out_status;
  logic                     out_last;

  logic                     slot_free;
  logic                     acc;
  logic                     emit;
  logic signed [WORD_W-1:0] e_item;
  logic [1:0]               e_status;
  logic                     e_last;
  logic                     rot;
  logic                     shr;
  logic                     ldb;
  logic                     full;
  logic                     empty;
  logic                     k_live;
  logic                     adv;
  logic                     is_push;

  cell_ctl_t                ctl [DEPTH];
  logic signed [WORD_W-1:0] cq  [DEPTH];

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign acc       = req.valid && req.ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign k_live    = (CNT_W'(k) < count);
  assign adv       = k_live ? slot_free : 1'b1;
  assign is_push   = (req.req_type == REQ_PUSH_FRONT) || (req.req_type == REQ_PUSH_BACK);

  always_comb begin
    state_next = state;
    count_next = count;
    k_next     = k;
    emit       = 1'b0;
    e_item     = '0;
    e_status   = ST_OK;
    e_last     = 1'b1;
    rot        = 1'b0;
    shr        = 1'b0;
    ldb        = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (req.req_type)
            REQ_PUSH_FRONT: begin
              emit = 1'b1;
              if (full) begin
                e_status = ST_FULL;
              end else begin
                shr        = 1'b1;
                count_next = count + 1'b1;
              end
            end
            REQ_PUSH_BACK: begin
              emit = 1'b1;
              if (full) begin
                e_status = ST_FULL;
              end else begin
                ldb        = 1'b1;
                count_next = count + 1'b1;
              end
            end
            REQ_POP_FRONT: begin
              emit = 1'b1;
              if (empty) begin
                e_status = ST_EMPTY;
              end else begin
                rot        = 1'b1;
                count_next = count - 1'b1;
              end
            end
            REQ_POP_BACK: begin
              emit = 1'b1;
              if (empty) begin
                e_status = ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            REQ_LIST: begin
              if (empty) begin
                emit     = 1'b1;
                e_status = ST_EMPTY;
              end else begin
                state_next = S_LIST;
                k_next     = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_LIST: begin
        if (adv) begin
          rot = 1'b1;
          if (k_live) begin
            emit   = 1'b1;
            e_item = cq[0];
            e_last = (CNT_W'(k) + 1'b1 == count);
          end
          if (k == IDX_W'(DEPTH - 1)) begin
            k_next     = '0;
            state_next = S_IDLE;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].ld = req.value;
      if (rot) begin
        ctl[i].op = CELL_FROM_RIGHT;
      end else if (shr) begin
        ctl[i].op = (i == 0) ? CELL_LOAD : CELL_FROM_LEFT;
      end else if (ldb && (count[IDX_W-1:0] == IDX_W'(i))) begin
        ctl[i].op = CELL_LOAD;
      end else begin
        ctl[i].op = CELL_HOLD;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bde_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[g]),
      .left_d  (cq[(g + DEPTH - 1) % DEPTH]),
      .right_d (cq[(g + 1) % DEPTH]),
      .q       (cq[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      k     <= k_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item   <= e_item;
      out_status <= e_status;
      out_last   <= e_last;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.item   = out_item;
  assign rsp.status = out_status;
  assign rsp.last   = out_last;

  `BDE_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(DEPTH))
  `BDE_ASSERT_NOW(a_no_accept_listing, state == S_LIST, !req.ready)
  `BDE_ASSERT_NEXT(a_full_push_keeps, acc && full && is_push, count == $past(count))
  `BDE_ASSERT_NEXT(a_list_ends, state == S_LIST && adv && k == IDX_W'(DEPTH - 1), state == S_IDLE)

endmodule
